// ----- rtl/flash_block_owner_table_macros.svh -----
// ----------------------------------------------------------------------------
// Flash block owner table assertion macros
// Clocked concurrent assertion helpers used by the table top level.
// ----------------------------------------------------------------------------
`ifndef FLASH_BLOCK_OWNER_TABLE_MACROS_SVH
`define FLASH_BLOCK_OWNER_TABLE_MACROS_SVH

// Check on every clock edge outside reset.
`define FBOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define FBOT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- rtl/fbot_pkg.sv -----
// ----------------------------------------------------------------------------
// Flash block owner table package
// Word types, entry layout, command, kind and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbot_pkg;

    localparam int DEF_NUM_BLOCKS      = 4096;
    localparam int DEF_PAGES_PER_BLOCK = 256;
    localparam int ADDR_W              = 20;

    localparam logic [2:0] CMD_ASSIGN_NORMAL = 3'd0;
    localparam logic [2:0] CMD_ASSIGN_MIXED  = 3'd1;
    localparam logic [2:0] CMD_MOVE_OWNER    = 3'd2;
    localparam logic [2:0] CMD_FRAGMENT      = 3'd3;
    localparam logic [2:0] CMD_MARK_MIXED    = 3'd4;
    localparam logic [2:0] CMD_RELEASE       = 3'd5;
    localparam logic [2:0] CMD_LOOKUP        = 3'd6;

    localparam logic [2:0] KIND_EMPTY    = 3'd0;
    localparam logic [2:0] KIND_NORMAL   = 3'd1;
    localparam logic [2:0] KIND_MIXED    = 3'd2;
    localparam logic [2:0] KIND_FRAGMENT = 3'd3;
    localparam logic [2:0] KIND_SUMMARY  = 3'd4;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BUSY = 2'd1;
    localparam logic [1:0] STAT_FREE = 2'd2;
    localparam logic [1:0] STAT_KIND = 2'd3;

    typedef struct packed {
        logic [2:0]        command;
        logic [ADDR_W-1:0] page_address;
        logic [5:0]        run_id;
        logic [31:0]       run_offset;
        logic [2:0]        target_kind;
        logic [63:0]       mask_in;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_assigned;
        logic [5:0]  owner_run;
        logic [31:0] owner_offset;
        logic [2:0]  block_kind;
        logic [63:0] mask_out;
    } t_result_word;

    typedef struct packed {
        logic        assigned;
        logic [5:0]  owner_run;
        logic [31:0] owner_offset;
        logic [2:0]  block_kind;
        logic [63:0] mask;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        assigned:     1'b0,
        owner_run:    6'h3f,
        owner_offset: 32'hffff_ffff,
        block_kind:   KIND_EMPTY,
        mask:         64'hffff_ffff_ffff_ffff
    };

endpackage

// ----- rtl/fbot_index.sv -----
// ----------------------------------------------------------------------------
// Block index pipeline
// Page address to table index: address / pages per block, modulo block count,
// by reciprocal multiplication over three registered stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbot_index #(
    parameter int NUM_BLOCKS      = fbot_pkg::DEF_NUM_BLOCKS,
    parameter int PAGES_PER_BLOCK = fbot_pkg::DEF_PAGES_PER_BLOCK
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [fbot_pkg::ADDR_W-1:0]       i_addr,
    output logic                              o_valid,
    output logic [$clog2(NUM_BLOCKS)-1:0]     o_idx
);
    import fbot_pkg::*;

    localparam int IW  = $clog2(NUM_BLOCKS);
    // quotient of the first division fits in QW bits
    localparam int QW  = ADDR_W - ($clog2(PAGES_PER_BLOCK + 1) - 1);

    localparam int S1  = ADDR_W + $clog2(PAGES_PER_BLOCK);
    localparam longint unsigned M1 =
        ((64'd1 << S1) + 64'(PAGES_PER_BLOCK) - 64'd1) / 64'(PAGES_PER_BLOCK);
    localparam int P1W = 2 * ADDR_W + 1;

    localparam int S2  = QW + IW;
    localparam longint unsigned M2 =
        ((64'd1 << S2) + 64'(NUM_BLOCKS) - 64'd1) / 64'(NUM_BLOCKS);
    localparam int P2W = 2 * QW + 1 + IW;

    localparam int PRW = QW + IW + 1;

    logic [P1W-1:0] w_prod1;
    logic [P2W-1:0] w_prod2;
    logic [PRW-1:0] w_rem;

    logic           r_v1;
    logic [QW-1:0]  r_q1;
    logic           r_v2;
    logic [QW-1:0]  r_q2;
    logic [QW-1:0]  r_d2;
    logic           r_v3;
    logic [IW-1:0]  r_idx;

    assign w_prod1 = P1W'(i_addr) * P1W'(M1);
    assign w_prod2 = P2W'(r_q1) * P2W'(M2);
    assign w_rem   = PRW'(r_q2) - PRW'(r_d2) * PRW'(NUM_BLOCKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1  <= w_prod1[S1 +: QW];
        r_q2  <= r_q1;
        r_d2  <= w_prod2[S2 +: QW];
        r_idx <= w_rem[IW-1:0];
    end

    assign o_valid = r_v3;
    assign o_idx   = r_idx;

endmodule

// ----- rtl/fbot_mem.sv -----
// ----------------------------------------------------------------------------
// Owner table memory
// One entry per block, one write and one registered read per cycle,
// swept to the reset entry after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbot_mem #(
    parameter int NUM_BLOCKS = fbot_pkg::DEF_NUM_BLOCKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_rd_addr,
    output fbot_pkg::t_entry              o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_wr_addr,
    input  fbot_pkg::t_entry              i_wr_data,
    output logic                          o_busy
);
    import fbot_pkg::*;

    localparam int IW = $clog2(NUM_BLOCKS);

    t_entry        r_mem [NUM_BLOCKS];
    t_entry        r_rd_data;
    logic          r_clr_busy;
    logic [IW-1:0] r_clr_ptr;

    logic          w_we;
    logic [IW-1:0] w_wa;
    t_entry        w_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_ptr  <= '0;
        end else if (r_clr_busy) begin
            r_clr_ptr <= r_clr_ptr + 1'b1;
            if (r_clr_ptr == IW'(NUM_BLOCKS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // sweep owns the write port until every entry holds the reset value
    assign w_we = r_clr_busy | i_wr_en;
    assign w_wa = r_clr_busy ? r_clr_ptr : i_wr_addr;
    assign w_wd = r_clr_busy ? ENTRY_RESET : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

// ----- rtl/fbot_update.sv -----
// ----------------------------------------------------------------------------
// Entry update logic
// Checks one command against the entry read from the table and forms the
// entry to write back and the status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbot_update (
    input  fbot_pkg::t_cmd_word i_cmd,
    input  fbot_pkg::t_entry    i_entry,
    output fbot_pkg::t_entry    o_entry,
    output logic [1:0]          o_status
);
    import fbot_pkg::*;

    t_entry      w_entry;
    logic [1:0]  w_status;
    logic [63:0] w_run_bit;

    assign w_run_bit = 64'd1 << i_cmd.run_id;

    always_comb begin
        w_entry  = i_entry;
        w_status = STAT_OK;
        case (i_cmd.command)
            CMD_ASSIGN_NORMAL, CMD_ASSIGN_MIXED: begin
                if (i_entry.assigned) begin
                    w_status = STAT_BUSY;
                end else begin
                    w_entry.assigned     = 1'b1;
                    w_entry.owner_run    = i_cmd.run_id;
                    w_entry.owner_offset = i_cmd.run_offset;
                    if (i_cmd.command == CMD_ASSIGN_NORMAL) begin
                        w_entry.block_kind = KIND_NORMAL;
                    end else begin
                        w_entry.block_kind = KIND_MIXED;
                        w_entry.mask       = i_cmd.mask_in;
                    end
                end
            end
            CMD_MOVE_OWNER: begin
                if (!i_entry.assigned) begin
                    w_status = STAT_FREE;
                end else if (i_entry.block_kind != KIND_NORMAL &&
                             i_entry.block_kind != KIND_MIXED) begin
                    w_status = STAT_KIND;
                end else begin
                    w_entry.owner_run    = i_cmd.run_id;
                    w_entry.owner_offset = i_cmd.run_offset;
                    w_entry.block_kind   = i_cmd.target_kind;
                end
            end
            CMD_FRAGMENT: begin
                // a mixed block keeps its owner; anything else drops it
                if (i_entry.block_kind != KIND_MIXED) begin
                    w_entry.assigned     = 1'b0;
                    w_entry.owner_run    = ENTRY_RESET.owner_run;
                    w_entry.owner_offset = ENTRY_RESET.owner_offset;
                    w_entry.block_kind   = KIND_FRAGMENT;
                end
                w_entry.mask = i_entry.mask | w_run_bit;
            end
            CMD_MARK_MIXED: begin
                if (i_entry.block_kind == KIND_NORMAL) begin
                    w_entry.block_kind = KIND_MIXED;
                end
                w_entry.mask = i_entry.mask | w_run_bit;
            end
            CMD_RELEASE: begin
                w_entry.assigned  = 1'b0;
                w_entry.owner_run = ENTRY_RESET.owner_run;
            end
            default: begin
                // lookup and the unused code leave the entry alone
            end
        endcase
    end

    assign o_entry  = w_entry;
    assign o_status = w_status;

endmodule

// ----- rtl/flash_block_owner_table.sv -----
// One command word in, one result word out: the result shows the addressed
// table entry after the command, with a status. A command passes through the
// index pipeline that turns the page address into a table index by reciprocal
// multiplication, then the registered table read, then the read-modify-write
// and result load before the next command is accepted; a result not yet taken
// by the consumer holds off the write-back of the next command and with it the
// acceptance of further commands. After reset the table is swept to its reset
// entry, one entry a cycle, so no command is accepted until all NUM_BLOCKS
// entries (4096 by default) are swept.
// ----------------------------------------------------------------------------
// Flash block owner table
// Per-block owner, run index, kind and fragment mask for a flash translation
// layer, updated by one read-modify-write per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flash_block_owner_table_macros.svh"

module flash_block_owner_table #(
    parameter int NUM_BLOCKS      = fbot_pkg::DEF_NUM_BLOCKS,
    parameter int PAGES_PER_BLOCK = fbot_pkg::DEF_PAGES_PER_BLOCK
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  fbot_pkg::t_cmd_word    i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output fbot_pkg::t_result_word o_out_word
);
    import fbot_pkg::*;

    localparam int IW = $clog2(NUM_BLOCKS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_INDEX  = 2'd1;
    localparam logic [1:0] S_MODIFY = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    t_cmd_word     r_cmd;
    logic [IW-1:0] r_idx;
    logic          r_out_valid;
    logic          n_out_valid;
    t_result_word  r_out_word;

    logic          w_accept;
    logic          w_idx_valid;
    logic [IW-1:0] w_idx;
    logic          w_mem_busy;
    t_entry        w_rd_entry;
    t_entry        w_new_entry;
    logic [1:0]    w_status;
    logic          w_slot_free;
    logic          w_commit;
    logic          w_rd_en;

    assign o_in_ready  = (r_state == S_IDLE) && !w_mem_busy;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_commit    = (r_state == S_MODIFY) && w_slot_free;
    assign w_rd_en     = (r_state == S_INDEX) && w_idx_valid;

    fbot_index #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_addr  (i_in_word.page_address),
        .o_valid (w_idx_valid),
        .o_idx   (w_idx)
    );

    fbot_mem #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_idx),
        .o_rd_data (w_rd_entry),
        .i_wr_en   (w_commit),
        .i_wr_addr (r_idx),
        .i_wr_data (w_new_entry),
        .o_busy    (w_mem_busy)
    );

    fbot_update u_update (
        .i_cmd    (r_cmd),
        .i_entry  (w_rd_entry),
        .o_entry  (w_new_entry),
        .o_status (w_status)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_INDEX;
                end
            end
            S_INDEX: begin
                if (w_idx_valid) begin
                    n_state = S_MODIFY;
                end
            end
            S_MODIFY: begin
                // hold the read data until the result register frees up
                if (w_slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_word;
        end
        if (w_rd_en) begin
            r_idx <= w_idx;
        end
        if (w_commit) begin
            r_out_word.status       <= w_status;
            r_out_word.is_assigned  <= w_new_entry.assigned;
            r_out_word.owner_run    <= w_new_entry.owner_run;
            r_out_word.owner_offset <= w_new_entry.owner_offset;
            r_out_word.block_kind   <= w_new_entry.block_kind;
            r_out_word.mask_out     <= w_new_entry.mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `FBOT_ASSERT(a_accept_starts_index, w_accept |=> (r_state == S_INDEX), "accepted word did not enter index stage")
    `FBOT_ASSERT(a_index_only_when_waiting, w_idx_valid |-> (r_state == S_INDEX), "index pipeline output outside index wait")
    `FBOT_ASSERT(a_index_in_range, w_idx_valid |-> (int'(w_idx) < NUM_BLOCKS), "block index beyond table")
    `FBOT_ASSERT(a_no_write_during_sweep, w_mem_busy |-> !w_commit, "table write-back during reset sweep")
    `FBOT_ASSERT(a_commit_loads_result, w_commit |=> o_out_valid, "write-back without result")

endmodule
